// File: rtl/core/assert_macros.svh
// Assertion macros shared by the peak detector RTL.
// Expects clk and arst_n in the scope of each use; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ATPD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("atpd: same-cycle check failed");

// next-cycle implication
`define ATPD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("atpd: next-cycle check failed");

`endif

// File: rtl/core/atpd_pkg.sv
// Package of the adaptive threshold peak detector: widths, constants, codes,
// controller states and the command/status structs. No dependencies.
package atpd_pkg;

	localparam int UPDATE_PERIOD = 1024;
	localparam int PHASE_W = (UPDATE_PERIOD > 1) ? $clog2(UPDATE_PERIOD) : 1;
	localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(UPDATE_PERIOD - 1);

	localparam int SAMPLE_W = 16;
	localparam int TIME_W = 48;
	localparam int INDEX_W = 32;
	localparam int MPS_W = 32;
	localparam int TIME_FRAC = 16;
	localparam int SUM_W = 48;
	localparam int SQSUM_W = 64;
	localparam int MEAN_W = SAMPLE_W + 1;
	localparam int MSQ_W = 31;
	localparam int THR_W = MEAN_W + 2;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 48;

	localparam int DIV_N_W = 64;
	localparam int DIV_D_W = 32;
	localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

	localparam int SQRT_W = 32;
	localparam int ROOT_W = 16;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic [MPS_W-1:0] MPS_RESET = 32'h0001_0000;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_INIT_THR      = 2'd0,
		REG_START_TIME    = 2'd1,
		REG_SAMPLE_PERIOD = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_MSQ_WAIT,
		ST_SQRT_GO,
		ST_SQRT_WAIT,
		ST_THR,
		ST_DETECT,
		ST_PING_MUL,
		ST_PING_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic in_ready;
		logic exec;
		logic detect;
		logic div_mean_go;
		logic div_msq_go;
		logic mean_ld;
		logic var_ld;
		logic sqrt_go;
		logic thr_ld;
		logic ping_mul;
		logic out_ld;
	} dp_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic due;
		logic below;
		logic over;
		logic div_done;
		logic sqrt_done;
		logic out_free;
	} dp_status_t;

endpackage

// File: rtl/core/atpd_channels.sv
// Handshake channels of the peak detector: sample input, ping output and
// configuration writes. Depends on atpd_pkg.
interface atpd_sample_if;
	logic valid;
	logic ready;
	logic signed [atpd_pkg::SAMPLE_W-1:0] sample;
	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface atpd_ping_if;
	logic valid;
	logic ready;
	logic [atpd_pkg::TIME_W-1:0] ping_time_ms;
	logic signed [atpd_pkg::SAMPLE_W-1:0] ping_amplitude;
	logic [atpd_pkg::INDEX_W-1:0] ping_index;
	modport source (output valid, output ping_time_ms, output ping_amplitude,
		output ping_index, input ready);
	modport sink (input valid, input ping_time_ms, input ping_amplitude,
		input ping_index, output ready);
endinterface

interface atpd_cfg_if;
	logic valid;
	logic ready;
	logic [atpd_pkg::CFG_INDEX_W-1:0] index;
	logic [atpd_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/adaptive_threshold_peak_detector_core.sv
// A new sample is accepted only in the idle state, once the previous sample and any ping that
// it causes are through; a held ping that is not taken blocks the next one. The last sample
// of each update period also runs the shared 64-step divider twice and the 16-step root unit
// to update the threshold.
// Reset (arst_n low, asynchronous): threshold 0, sample period 1.0 ms, start time 0, peak
// at the most negative value, counters and sums cleared, no ping; uses atpd_ctrl, atpd_dp.
module adaptive_threshold_peak_detector_core (
	input  logic clk,
	input  logic arst_n,
	atpd_cfg_if.sink cfg,
	atpd_sample_if.sink samples,
	atpd_ping_if.source pings
);

	atpd_pkg::dp_cmd_t cmd;
	atpd_pkg::dp_status_t status;

	atpd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	atpd_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.status  (status),
		.samples (samples),
		.pings   (pings),
		.cfg     (cfg)
	);

endmodule

// File: rtl/core/atpd_div.sv
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on atpd_pkg.
module atpd_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [atpd_pkg::DIV_N_W-1:0] dividend,
	input  logic [atpd_pkg::DIV_D_W-1:0] divisor,
	output logic [atpd_pkg::DIV_N_W-1:0] quotient,
	output logic busy,
	output logic done
);

	logic [atpd_pkg::DIV_CNT_W-1:0] cnt_q;
	logic done_q;
	logic [atpd_pkg::DIV_D_W-1:0] rem_q;
	logic [atpd_pkg::DIV_D_W-1:0] dsr_q;
	logic [atpd_pkg::DIV_N_W-1:0] quo_q;
	logic [atpd_pkg::DIV_D_W:0] rem_shift;
	logic [atpd_pkg::DIV_D_W:0] rem_diff;
	logic ge;

	assign rem_shift = {rem_q, quo_q[atpd_pkg::DIV_N_W-1]};
	assign ge = rem_shift >= {1'b0, dsr_q};
	assign rem_diff = rem_shift - {1'b0, dsr_q};
	assign busy = cnt_q != '0;
	assign done = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q <= atpd_pkg::DIV_CNT_W'(atpd_pkg::DIV_N_W);
			done_q <= 1'b0;
		end else if (busy) begin
			cnt_q <= cnt_q - atpd_pkg::DIV_CNT_W'(1);
			done_q <= cnt_q == atpd_pkg::DIV_CNT_W'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy) begin
			rem_q <= ge ? rem_diff[atpd_pkg::DIV_D_W-1:0] : rem_shift[atpd_pkg::DIV_D_W-1:0];
			quo_q <= {quo_q[atpd_pkg::DIV_N_W-2:0], ge};
		end
	end

endmodule

// File: rtl/core/atpd_sqrt.sv
// Integer square root, one result bit per cycle (digit-by-digit method).
// Depends on atpd_pkg.
module atpd_sqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [atpd_pkg::SQRT_W-1:0] value,
	output logic [atpd_pkg::ROOT_W-1:0] root,
	output logic busy,
	output logic done
);

	localparam logic [atpd_pkg::SQRT_W-1:0] StepTop =
		atpd_pkg::SQRT_W'(1) << (atpd_pkg::SQRT_W - 2);

	logic [atpd_pkg::SQRT_W-1:0] step_q;
	logic done_q;
	logic [atpd_pkg::SQRT_W-1:0] rad_q;
	logic [atpd_pkg::SQRT_W-1:0] res_q;
	logic [atpd_pkg::SQRT_W-1:0] trial;
	logic ge;

	assign trial = res_q + step_q;
	assign ge = rad_q >= trial;
	assign busy = step_q != '0;
	assign done = done_q;
	assign root = res_q[atpd_pkg::ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			step_q <= StepTop;
			done_q <= 1'b0;
		end else if (busy) begin
			step_q <= step_q >> 2;
			done_q <= step_q == atpd_pkg::SQRT_W'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= value;
			res_q <= '0;
		end else if (busy) begin
			if (ge) begin
				rad_q <= rad_q - trial;
				res_q <= (res_q >> 1) + step_q;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

endmodule

// File: rtl/core/atpd_dp.sv
// Datapath: peak tracking, statistics accumulators, threshold update, ping
// formation and output register. Uses atpd_div, atpd_sqrt, atpd_pkg, channels.
`include "assert_macros.svh"
module atpd_dp (
	input  logic clk,
	input  logic arst_n,
	input  atpd_pkg::dp_cmd_t cmd,
	output atpd_pkg::dp_status_t status,
	atpd_sample_if.sink samples,
	atpd_ping_if.source pings,
	atpd_cfg_if.sink cfg
);

	logic signed [atpd_pkg::SAMPLE_W-1:0] sample_q;
	logic signed [atpd_pkg::SAMPLE_W-1:0] peak_value_q;
	logic signed [atpd_pkg::SAMPLE_W-1:0] thr_q;
	logic [atpd_pkg::INDEX_W-1:0] peak_index_q;
	logic [atpd_pkg::INDEX_W-1:0] sample_count_q;
	logic [atpd_pkg::INDEX_W-1:0] stat_count_q;
	logic [atpd_pkg::PHASE_W-1:0] phase_q;
	logic signed [atpd_pkg::SUM_W-1:0] sum_q;
	logic [atpd_pkg::SQSUM_W-1:0] sqsum_q;
	logic [atpd_pkg::TIME_W-1:0] start_time_q;
	logic [atpd_pkg::MPS_W-1:0] mps_q;
	logic signed [atpd_pkg::MEAN_W-1:0] mean_q;
	logic [atpd_pkg::MSQ_W-1:0] m2_q;
	logic [atpd_pkg::MSQ_W-1:0] var_q;
	logic [2*atpd_pkg::INDEX_W-1:0] prod_q;
	logic out_valid_q;
	logic [atpd_pkg::TIME_W-1:0] out_time_q;
	logic signed [atpd_pkg::SAMPLE_W-1:0] out_amp_q;
	logic [atpd_pkg::INDEX_W-1:0] out_index_q;

	logic accept;
	logic signed [atpd_pkg::SAMPLE_W-1:0] peak_new;
	logic peak_gt;
	logic below;
	logic over;
	logic stat_full;
	logic signed [2*atpd_pkg::SAMPLE_W-1:0] square_w;
	logic [atpd_pkg::SUM_W-1:0] sum_mag;
	logic div_start;
	logic [atpd_pkg::DIV_N_W-1:0] div_dividend;
	logic [atpd_pkg::DIV_N_W-1:0] quo;
	logic div_busy;
	logic div_done;
	logic signed [atpd_pkg::MEAN_W-1:0] mean_mag;
	logic signed [2*atpd_pkg::MEAN_W-1:0] m2_full;
	logic [atpd_pkg::MSQ_W-1:0] msq_w;
	logic [atpd_pkg::ROOT_W-1:0] root;
	logic sqrt_busy;
	logic sqrt_done;
	logic [atpd_pkg::ROOT_W+1:0] three_sd;
	logic signed [atpd_pkg::THR_W-1:0] thr_sum;
	logic signed [atpd_pkg::SAMPLE_W-1:0] thr_sat;
	logic [2*atpd_pkg::INDEX_W-1:0] prod_w;
	logic [atpd_pkg::TIME_W:0] time_sum;
	logic [atpd_pkg::TIME_W-1:0] time_sat;

	assign samples.ready = cmd.in_ready;
	assign accept = samples.valid && samples.ready;
	assign cfg.ready = 1'b1;

	assign peak_gt = sample_q > peak_value_q;
	assign peak_new = peak_gt ? sample_q : peak_value_q;
	assign below = sample_q < thr_q;
	assign over = peak_new > thr_q;
	assign stat_full = &stat_count_q;
	assign square_w = sample_q * sample_q;
	assign sum_mag = sum_q[atpd_pkg::SUM_W-1] ? atpd_pkg::SUM_W'(-sum_q) : sum_q;

	assign div_start = cmd.div_mean_go || cmd.div_msq_go;
	assign div_dividend = cmd.div_msq_go ? sqsum_q
		: {{(atpd_pkg::DIV_N_W-atpd_pkg::SUM_W){1'b0}}, sum_mag};

	atpd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (stat_count_q),
		.quotient (quo),
		.busy     (div_busy),
		.done     (div_done)
	);

	assign mean_mag = $signed({1'b0, quo[atpd_pkg::MEAN_W-2:0]});
	assign m2_full = mean_q * mean_q;
	assign msq_w = quo[atpd_pkg::MSQ_W-1:0];

	atpd_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sqrt_go),
		.value  ({{(atpd_pkg::SQRT_W-atpd_pkg::MSQ_W){1'b0}}, var_q}),
		.root   (root),
		.busy   (sqrt_busy),
		.done   (sqrt_done)
	);

	assign three_sd = {2'b00, root} + {1'b0, root, 1'b0};
	assign thr_sum = $signed({{2{mean_q[atpd_pkg::MEAN_W-1]}}, mean_q})
		+ $signed({1'b0, three_sd});

	always_comb begin
		priority if (thr_sum > atpd_pkg::THR_W'(atpd_pkg::SAMPLE_MAX))
			thr_sat = atpd_pkg::SAMPLE_MAX;
		else if (thr_sum < atpd_pkg::THR_W'(atpd_pkg::SAMPLE_MIN))
			thr_sat = atpd_pkg::SAMPLE_MIN;
		else
			thr_sat = thr_sum[atpd_pkg::SAMPLE_W-1:0];
	end

	assign prod_w = peak_index_q * mps_q;
	assign time_sum = {1'b0, prod_q[2*atpd_pkg::INDEX_W-1:atpd_pkg::TIME_FRAC]}
		+ {1'b0, start_time_q};
	assign time_sat = time_sum[atpd_pkg::TIME_W] ? '1 : time_sum[atpd_pkg::TIME_W-1:0];

	assign status.in_valid = samples.valid;
	assign status.due = phase_q == atpd_pkg::PHASE_LAST;
	assign status.below = below;
	assign status.over = over;
	assign status.div_done = div_done;
	assign status.sqrt_done = sqrt_done;
	assign status.out_free = !out_valid_q || pings.ready;

	assign pings.valid = out_valid_q;
	assign pings.ping_time_ms = out_time_q;
	assign pings.ping_amplitude = out_amp_q;
	assign pings.ping_index = out_index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_value_q <= atpd_pkg::SAMPLE_MIN;
			peak_index_q <= '0;
			sample_count_q <= '0;
			stat_count_q <= '0;
			phase_q <= '0;
			sum_q <= '0;
			sqsum_q <= '0;
			thr_q <= '0;
			start_time_q <= '0;
			mps_q <= atpd_pkg::MPS_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_ld) begin
				peak_value_q <= atpd_pkg::SAMPLE_MIN;
			end else if (cmd.detect && below && !over) begin
				peak_value_q <= atpd_pkg::SAMPLE_MIN;
			end else if (cmd.exec) begin
				peak_value_q <= peak_new;
			end
			if (cmd.exec) begin
				if (peak_gt)
					peak_index_q <= sample_count_q;
				sample_count_q <= sample_count_q + atpd_pkg::INDEX_W'(1);
				if (&sample_count_q || phase_q == atpd_pkg::PHASE_LAST)
					phase_q <= '0;
				else
					phase_q <= phase_q + atpd_pkg::PHASE_W'(1);
				if (!stat_full) begin
					stat_count_q <= stat_count_q + atpd_pkg::INDEX_W'(1);
					sum_q <= sum_q + $signed({{(atpd_pkg::SUM_W-atpd_pkg::SAMPLE_W)
						{sample_q[atpd_pkg::SAMPLE_W-1]}}, sample_q});
					sqsum_q <= sqsum_q + {{(atpd_pkg::SQSUM_W-2*atpd_pkg::SAMPLE_W){1'b0}},
						square_w};
				end
			end
			if (cfg.valid) begin
				unique case (atpd_pkg::cfg_reg_t'(cfg.index))
					atpd_pkg::REG_INIT_THR: begin
						thr_q <= $signed(cfg.data[atpd_pkg::SAMPLE_W-1:0]);
					end
					atpd_pkg::REG_START_TIME: begin
						start_time_q <= cfg.data[atpd_pkg::TIME_W-1:0];
					end
					atpd_pkg::REG_SAMPLE_PERIOD: begin
						mps_q <= cfg.data[atpd_pkg::MPS_W-1:0];
					end
					default: begin
					end
				endcase
			end else if (cmd.thr_ld) begin
				thr_q <= thr_sat;
			end
			if (cmd.out_ld)
				out_valid_q <= 1'b1;
			else if (pings.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			sample_q <= samples.sample;
		if (cmd.mean_ld)
			mean_q <= sum_q[atpd_pkg::SUM_W-1] ? -mean_mag : mean_mag;
		m2_q <= m2_full[atpd_pkg::MSQ_W-1:0];
		if (cmd.var_ld)
			var_q <= (msq_w > m2_q) ? msq_w - m2_q : '0;
		if (cmd.ping_mul)
			prod_q <= prod_w;
		if (cmd.out_ld) begin
			out_time_q <= time_sat;
			out_amp_q <= peak_value_q;
			out_index_q <= peak_index_q;
		end
	end

	`ATPD_ASSERT_IMP(a_no_overwrite, cmd.out_ld, !out_valid_q || pings.ready)
	`ATPD_ASSERT_NXT(a_stat_frozen, stat_full, stat_full)
	`ATPD_ASSERT_IMP(a_units_idle_on_accept, accept, !div_busy && !sqrt_busy)

endmodule

// File: rtl/core/atpd_ctrl.sv
// Controller of the peak detector: sequences accumulate, threshold update
// and ping steps. Depends on atpd_pkg.
module atpd_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  atpd_pkg::dp_status_t status,
	output atpd_pkg::dp_cmd_t cmd
);

	atpd_pkg::ctrl_state_t state_q;
	atpd_pkg::ctrl_state_t state_d;
	logic ping;

	assign ping = status.below && status.over;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= atpd_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			atpd_pkg::ST_IDLE: begin
				if (status.in_valid)
					state_d = atpd_pkg::ST_EXEC;
			end
			atpd_pkg::ST_EXEC: begin
				priority if (status.due)
					state_d = atpd_pkg::ST_MEAN_GO;
				else if (ping)
					state_d = atpd_pkg::ST_PING_MUL;
				else
					state_d = atpd_pkg::ST_IDLE;
			end
			atpd_pkg::ST_MEAN_GO: state_d = atpd_pkg::ST_MEAN_WAIT;
			atpd_pkg::ST_MEAN_WAIT: begin
				if (status.div_done)
					state_d = atpd_pkg::ST_MSQ_WAIT;
			end
			atpd_pkg::ST_MSQ_WAIT: begin
				if (status.div_done)
					state_d = atpd_pkg::ST_SQRT_GO;
			end
			atpd_pkg::ST_SQRT_GO: state_d = atpd_pkg::ST_SQRT_WAIT;
			atpd_pkg::ST_SQRT_WAIT: begin
				if (status.sqrt_done)
					state_d = atpd_pkg::ST_THR;
			end
			atpd_pkg::ST_THR: state_d = atpd_pkg::ST_DETECT;
			atpd_pkg::ST_DETECT: begin
				state_d = ping ? atpd_pkg::ST_PING_MUL : atpd_pkg::ST_IDLE;
			end
			atpd_pkg::ST_PING_MUL: state_d = atpd_pkg::ST_PING_OUT;
			atpd_pkg::ST_PING_OUT: begin
				if (status.out_free)
					state_d = atpd_pkg::ST_IDLE;
			end
			default: state_d = atpd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			atpd_pkg::ST_IDLE: cmd.in_ready = 1'b1;
			atpd_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				cmd.detect = !status.due;
			end
			atpd_pkg::ST_MEAN_GO: cmd.div_mean_go = 1'b1;
			atpd_pkg::ST_MEAN_WAIT: begin
				cmd.mean_ld = status.div_done;
				cmd.div_msq_go = status.div_done;
			end
			atpd_pkg::ST_MSQ_WAIT: cmd.var_ld = status.div_done;
			atpd_pkg::ST_SQRT_GO: cmd.sqrt_go = 1'b1;
			atpd_pkg::ST_SQRT_WAIT: begin
			end
			atpd_pkg::ST_THR: cmd.thr_ld = 1'b1;
			atpd_pkg::ST_DETECT: cmd.detect = 1'b1;
			atpd_pkg::ST_PING_MUL: cmd.ping_mul = 1'b1;
			atpd_pkg::ST_PING_OUT: cmd.out_ld = status.out_free;
			default: begin
			end
		endcase
	end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of adaptive_threshold_peak_detector_core: drives samples and
// register writes, predicts pings with a mean-plus-three-sigma detector of its own and
// checks every ping field. Depends on atpd_pkg, atpd_channels and the core RTL.
module testbench;

	typedef longint unsigned u64_t;

	typedef struct {
		logic [atpd_pkg::TIME_W-1:0] time_ms;
		logic signed [atpd_pkg::SAMPLE_W-1:0] amp;
		logic [atpd_pkg::INDEX_W-1:0] index;
	} ping_rec_t;

	localparam logic [atpd_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;
	localparam logic [atpd_pkg::TIME_W-1:0] TIME_MAX = '1;
	localparam int SIGMA_K = 3;
	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE_LIMIT = 20000;
	localparam int UPDATE_DRAIN = 200;
	localparam int HOLD_CYCLES = 400;
	localparam logic signed [atpd_pkg::SAMPLE_W-1:0] EDGE_AMPS [11] = '{
		16'sh7FFF, 16'sh7FFF, 16'sd100, 16'sd99, 16'sh8000, 16'sd100,
		-16'sd1, 16'sd101, 16'sd0, 16'sh5555, 16'shAAAA
	};

	logic clk;
	logic arst_n;

	atpd_cfg_if cfg_bus();
	atpd_sample_if sample_bus();
	atpd_ping_if ping_bus();

	adaptive_threshold_peak_detector_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.samples(sample_bus),
		.pings(ping_bus)
	);

	// detector state
	logic signed [atpd_pkg::SAMPLE_W-1:0] held_peak;
	logic [atpd_pkg::INDEX_W-1:0] held_index;
	logic [atpd_pkg::INDEX_W-1:0] sample_count;
	logic [31:0] stat_n;
	longint acc_sum;
	u64_t acc_sq;
	int threshold_q;
	logic [atpd_pkg::TIME_W-1:0] t0_ms;
	logic [atpd_pkg::MPS_W-1:0] ms_step;

	ping_rec_t due_pings[$];
	ping_rec_t head_ping;
	logic signed [atpd_pkg::SAMPLE_W-1:0] pending_samples[$];
	logic signed [atpd_pkg::SAMPLE_W-1:0] last_spike;

	int send_idle_pct;
	int recv_idle_pct;
	int mismatches = 0;
	int pings_seen = 0;
	int unsigned samples_taken = 0;
	int unsigned hold_at = 32'hFFFF_FFFF;
	int hold_left = 0;
	bit hold_done = 0;
	int cycle_count = 0;

	always #5ns clk = ~clk;

	function automatic u64_t int_sqrt(input u64_t v);
		u64_t r;
		u64_t c;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			c = r | (u64_t'(1) << b);
			if (c * c <= v)
				r = c;
		end
		return r;
	endfunction

	function automatic int stat_threshold();
		longint avg;
		longint lvl;
		u64_t n;
		u64_t msq;
		u64_t avg_sq;
		u64_t spread;
		n = {32'b0, stat_n};
		if (n == 0)
			return threshold_q;
		avg = acc_sum / longint'(n);
		msq = acc_sq / n;
		avg_sq = avg * avg;
		spread = (msq > avg_sq) ? msq - avg_sq : 0;
		lvl = avg + SIGMA_K * longint'(int_sqrt(spread));
		if (lvl > atpd_pkg::SAMPLE_MAX)
			lvl = atpd_pkg::SAMPLE_MAX;
		else if (lvl < atpd_pkg::SAMPLE_MIN)
			lvl = atpd_pkg::SAMPLE_MIN;
		return int'(lvl);
	endfunction

	task automatic detect_step(input logic signed [atpd_pkg::SAMPLE_W-1:0] s);
		ping_rec_t p;
		u64_t t;
		if (s > held_peak) begin
			held_peak = s;
			held_index = sample_count;
		end
		if (stat_n != '1) begin
			acc_sum += s;
			acc_sq += longint'(s) * longint'(s);
			stat_n++;
		end
		if (sample_count % atpd_pkg::UPDATE_PERIOD == atpd_pkg::UPDATE_PERIOD - 1)
			threshold_q = stat_threshold();
		if (s < threshold_q) begin
			if (held_peak > threshold_q) begin
				t = (({32'b0, held_index} * {32'b0, ms_step}) >> atpd_pkg::TIME_FRAC)
					+ {16'b0, t0_ms};
				if (t > {16'b0, TIME_MAX})
					t = {16'b0, TIME_MAX};
				p.time_ms = t[atpd_pkg::TIME_W-1:0];
				p.amp = held_peak;
				p.index = held_index;
				due_pings.push_back(p);
			end
			held_peak = atpd_pkg::SAMPLE_MIN;
		end
		sample_count++;
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("%0t mismatch in %s: got %0h, want %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic write_reg(input logic [atpd_pkg::CFG_INDEX_W-1:0] idx,
			input logic [atpd_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= val;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		case (idx)
			atpd_pkg::REG_INIT_THR:
				threshold_q = int'(signed'(val[atpd_pkg::SAMPLE_W-1:0]));
			atpd_pkg::REG_START_TIME: t0_ms = val[atpd_pkg::TIME_W-1:0];
			atpd_pkg::REG_SAMPLE_PERIOD: ms_step = val[atpd_pkg::MPS_W-1:0];
			default: ;
		endcase
	endtask

	task automatic setup(input logic [atpd_pkg::CFG_DATA_W-1:0] thr_word,
			input logic [atpd_pkg::TIME_W-1:0] start,
			input logic [atpd_pkg::MPS_W-1:0] step);
		write_reg(atpd_pkg::REG_INIT_THR, thr_word);
		write_reg(atpd_pkg::REG_START_TIME, start);
		write_reg(atpd_pkg::REG_SAMPLE_PERIOD, {16'b0, step});
	endtask

	// wait for every transfer and ping, then cover a threshold update in flight
	task automatic settle();
		int waited;
		waited = 0;
		while ((pending_samples.size() != 0 || sample_bus.valid || due_pings.size() != 0)
				&& waited < SETTLE_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (UPDATE_DRAIN) @(posedge clk);
	endtask

	// mostly low noise with spikes and dips, some full-range values and repeated peaks
	function automatic logic signed [atpd_pkg::SAMPLE_W-1:0] draw_amplitude();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70)
			return 16'($urandom_range(511)) - 16'd256;
		if (pick < 82) begin
			last_spike = 16'($urandom_range(20000, 1000));
			return last_spike;
		end
		if (pick < 87)
			return -16'($urandom_range(8000, 1000));
		if (pick < 92)
			return 16'($urandom);
		return last_spike;
	endfunction

	task automatic push_random(input int n);
		repeat (n) pending_samples.push_back(draw_amplitude());
	endtask

	always @(posedge clk) begin
		if (sample_bus.valid && sample_bus.ready) begin
			detect_step(sample_bus.sample);
			samples_taken <= samples_taken + 1;
		end
		if (!sample_bus.valid || sample_bus.ready) begin
			if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				sample_bus.valid <= 1'b1;
				sample_bus.sample <= pending_samples.pop_front();
			end else begin
				sample_bus.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!hold_done && samples_taken >= hold_at) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		if (ping_bus.valid && ping_bus.ready) begin
			pings_seen++;
			if (due_pings.size() == 0) begin
				report("ping with none pending, index", ping_bus.ping_index, '0);
			end else begin
				head_ping = due_pings.pop_front();
				if (ping_bus.ping_time_ms !== head_ping.time_ms)
					report("ping_time_ms", ping_bus.ping_time_ms, head_ping.time_ms);
				if (ping_bus.ping_amplitude !== head_ping.amp)
					report("ping_amplitude", ping_bus.ping_amplitude, head_ping.amp);
				if (ping_bus.ping_index !== head_ping.index)
					report("ping_index", ping_bus.ping_index, head_ping.index);
			end
		end
		ping_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	initial begin
		int extra;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = atpd_pkg::REG_INIT_THR;
		cfg_bus.data = '0;
		sample_bus.valid = 1'b0;
		sample_bus.sample = '0;
		ping_bus.ready = 1'b0;
		held_peak = atpd_pkg::SAMPLE_MIN;
		held_index = '0;
		sample_count = '0;
		stat_n = '0;
		acc_sum = 0;
		acc_sq = 0;
		threshold_q = 0;
		t0_ms = '0;
		ms_step = atpd_pkg::MPS_RESET;
		last_spike = 16'sd4000;
		send_idle_pct = 24;
		recv_idle_pct = 48;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// ties, extremes and the peak reset; the unmapped write must change nothing
		setup(48'hABCD_1234_0064, 48'd1000, 32'h0001_8000);
		write_reg(REG_UNMAPPED, 48'hFFFF_FFFF_FFFF);
		foreach (EDGE_AMPS[i]) pending_samples.push_back(EDGE_AMPS[i]);
		settle();

		// lowest threshold: nothing can fall below it
		setup(48'hFFFF_FFFF_8000, 48'hFFFF_FFFF_FF00, 32'hFFFF_FFFF);
		pending_samples.push_back(16'sh7FFF);
		pending_samples.push_back(16'sh8000);
		pending_samples.push_back(16'sd0);
		settle();

		// highest threshold: no peak can exceed it
		setup(48'h0000_0000_7FFF, 48'hFFFF_FFFF_FF00, 32'hFFFF_FFFF);
		pending_samples.push_back(16'sh7FFF);
		pending_samples.push_back(16'sh8000);
		settle();

		// saturate the ping time
		setup(48'h0, 48'hFFFF_FFFF_FF00, 32'hFFFF_FFFF);
		pending_samples.push_back(16'sd500);
		pending_samples.push_back(-16'sd500);
		settle();

		setup(48'h0, 48'h0, 32'h0);
		pending_samples.push_back(16'sd300);
		pending_samples.push_back(-16'sd300);
		settle();

		setup({16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)}, $urandom);
		push_random(700);
		settle();

		send_idle_pct = 48;
		recv_idle_pct = 24;
		setup({32'($urandom), 16'($urandom_range(600)) - 16'd300}, 48'h0, 32'hFFFF_FFFF);
		push_random(700);
		settle();

		// hold off pings mid-phase while samples keep coming
		send_idle_pct = 0;
		recv_idle_pct = 0;
		setup({32'($urandom), 16'($urandom_range(4000)) - 16'd2000}, TIME_MAX, $urandom);
		hold_at = samples_taken + 150;
		push_random(650);
		settle();

		extra = 0;
		while (pings_seen < 48 && extra < 8) begin
			setup({32'($urandom), 16'($urandom_range(600)) - 16'd300},
				{16'($urandom), 32'($urandom)}, $urandom);
			push_random(120);
			settle();
			extra++;
		end

		foreach (due_pings[i])
			report("ping never delivered, index", due_pings[i].index, '0);
		if (mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/atpd_pkg.sv
rtl/core/atpd_channels.sv
rtl/core/atpd_div.sv
rtl/core/atpd_sqrt.sv
rtl/core/atpd_dp.sv
rtl/core/atpd_ctrl.sv
rtl/core/adaptive_threshold_peak_detector_core.sv
dv/testbench.sv
